// ===== rtl/core/sddw_pkg.sv =====
// Package: shared types, codes and the microcode table of the digit display writer.
`timescale 1ns / 1ps

package sddw_pkg;

  // Field widths fixed by the item formats
  localparam int VALUE_W = 28;
  localparam int POS_W   = 4;
  localparam int SYM_W   = 4;
  localparam int STEP_W  = 3;

  // Code-B symbols and fixed positions
  localparam logic [SYM_W-1:0] SYM_ZERO  = 4'h0;
  localparam logic [SYM_W-1:0] SYM_MINUS = 4'hA;
  localparam logic [SYM_W-1:0] SYM_BLANK = 4'hF;
  localparam logic [POS_W-1:0] FIRST_POS = 4'h1;

  // Reciprocal of ten for 32-bit inputs: q = (x * RECIP10) >> RECIP_SHIFT
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Microprogram step addresses
  localparam logic [STEP_W-1:0] STEP_LOAD  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_BLANK = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ZERO  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIGIT = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MINUS = 3'd4;

  // Datapath action of one step
  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_BLANK,
    ACT_ZERO,
    ACT_DIGIT,
    ACT_MINUS
  } act_t;

  // Jump condition: when true the step jumps to its target and does nothing else
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_CNT_ZERO,
    C_MAG_NZ,
    C_DIG_DONE,
    C_NO_MINUS
  } cond_t;

  // Sequencing after the action is carried out
  typedef enum logic [1:0] {
    NX_SEQ,
    NX_LOOP,
    NX_DONE
  } nxt_t;

  typedef struct packed {
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    nxt_t              nxt;
  } ctrl_word_t;

  // Control store
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{act: ACT_NOP, cond: C_NEVER, target: STEP_LOAD, nxt: NX_DONE};
    unique case (step)
      STEP_LOAD:  w = '{act: ACT_LOAD,  cond: C_NO_IN,    target: STEP_LOAD,  nxt: NX_SEQ};
      STEP_BLANK: w = '{act: ACT_BLANK, cond: C_CNT_ZERO, target: STEP_ZERO,  nxt: NX_LOOP};
      STEP_ZERO:  w = '{act: ACT_ZERO,  cond: C_MAG_NZ,   target: STEP_DIGIT, nxt: NX_DONE};
      STEP_DIGIT: w = '{act: ACT_DIGIT, cond: C_DIG_DONE, target: STEP_MINUS, nxt: NX_LOOP};
      STEP_MINUS: w = '{act: ACT_MINUS, cond: C_NO_MINUS, target: STEP_LOAD,  nxt: NX_DONE};
      default:    w = '{act: ACT_NOP,   cond: C_NEVER,    target: STEP_LOAD,  nxt: NX_DONE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/signed_decimal_digit_display_writer_core.sv =====
// Top level: microcoded writer of blank, digit and sign register writes for one signed value.
//
//  channel | ports                              | item contents
//  --------+------------------------------------+----------------------------------------
//  input   | in_tvalid/in_tready/in_tdata       | value (28-bit two's complement)
//  output  | out_tvalid/out_tready/out_tdata/.. | reg_address, reg_data, tlast = last
//  config  | cfg_wr_en/cfg_wr_data              | digits_in_use (4 bits, reset 8)
//
// One value at a time: a new value is not taken until the sequencer is back at the load step.
// Writes come from the five-step control store and the divide-by-ten unit, which yields one
// digit per digit step.
// The sequencer returns to the load step, passing at most the minus step, once the last
// write is loaded into the output register, so the next value can be taken while it waits.
// A stalled output holds the sequencer.
// rst_n is synchronous, active low; it clears step and output valid, sets digits_in_use to 8.
`timescale 1ns / 1ps

module signed_decimal_digit_display_writer_core #(
  parameter int MAX_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [27:0] value, [31:28] zero
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [3:0] reg_address, [7:4] reg_data
  output logic        out_tlast,   // last
  // configuration
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data  // digits_in_use
);

  localparam logic [sddw_pkg::POS_W-1:0] MAX_POS = sddw_pkg::POS_W'(MAX_DIGITS);

  // Control registers
  logic [sddw_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [3:0]                  diu_r;
  logic                        out_valid_r;

  // Datapath registers
  logic [sddw_pkg::VALUE_W-1:0] mag_r;
  logic                         neg_r;
  logic [sddw_pkg::POS_W-1:0]   cnt_r;
  logic [sddw_pkg::POS_W-1:0]   pos_r;
  logic [sddw_pkg::POS_W-1:0]   out_addr_r;
  logic [sddw_pkg::SYM_W-1:0]   out_data_r;
  logic                         out_last_r;

  sddw_pkg::ctrl_word_t cw;
  logic                 cond_hit;
  logic                 emits;
  logic                 slot_free;
  logic                 go;

  logic [sddw_pkg::VALUE_W-1:0] in_value;
  logic [sddw_pkg::VALUE_W-1:0] in_mag;
  logic [sddw_pkg::POS_W-1:0]   blanks;

  logic [59:0]                  prod;
  logic [sddw_pkg::VALUE_W-1:0] quot;
  logic [sddw_pkg::VALUE_W-1:0] quot_x10;
  logic [sddw_pkg::VALUE_W-1:0] rem_full;
  logic                         dig_final;

  logic [sddw_pkg::POS_W-1:0] em_addr;
  logic [sddw_pkg::SYM_W-1:0] em_data;
  logic                       em_last;

  // Input magnitude and clamped blank count
  assign in_value = in_tdata[sddw_pkg::VALUE_W-1:0];
  assign in_mag   = in_value[sddw_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
  assign blanks   = (diu_r > MAX_POS) ? MAX_POS : diu_r;

  // Divide by ten: reciprocal multiply, remainder by shift-add
  assign prod      = 60'(mag_r) * 60'(sddw_pkg::RECIP10);
  assign quot      = sddw_pkg::VALUE_W'(prod[59:sddw_pkg::RECIP_SHIFT]);
  assign quot_x10  = (quot << 3) + (quot << 1);
  assign rem_full  = mag_r - quot_x10;
  assign dig_final = (quot == '0) || (pos_r == MAX_POS);

  // Control store fetch and jump condition
  assign cw = sddw_pkg::ucode_rom(step_r);

  always_comb begin
    unique case (cw.cond)
      sddw_pkg::C_NEVER:    cond_hit = 1'b0;
      sddw_pkg::C_NO_IN:    cond_hit = !in_tvalid;
      sddw_pkg::C_CNT_ZERO: cond_hit = (cnt_r == '0);
      sddw_pkg::C_MAG_NZ:   cond_hit = (mag_r != '0);
      sddw_pkg::C_DIG_DONE: cond_hit = (mag_r == '0) || (pos_r > MAX_POS);
      sddw_pkg::C_NO_MINUS: cond_hit = !neg_r || (pos_r > MAX_POS);
      default:              cond_hit = 1'b0;
    endcase
  end

  assign emits     = (cw.act == sddw_pkg::ACT_BLANK) || (cw.act == sddw_pkg::ACT_ZERO) ||
                     (cw.act == sddw_pkg::ACT_DIGIT) || (cw.act == sddw_pkg::ACT_MINUS);
  assign slot_free = !out_valid_r || out_tready;
  assign go        = !cond_hit && (!emits || slot_free);
  assign in_tready = (step_r == sddw_pkg::STEP_LOAD);

  // Write produced by the current step
  always_comb begin
    em_addr = pos_r;
    em_data = sddw_pkg::SYM_BLANK;
    em_last = 1'b0;
    unique case (cw.act)
      sddw_pkg::ACT_BLANK: begin
        em_addr = cnt_r;
      end
      sddw_pkg::ACT_ZERO: begin
        em_addr = sddw_pkg::FIRST_POS;
        em_data = sddw_pkg::SYM_ZERO;
        em_last = 1'b1;
      end
      sddw_pkg::ACT_DIGIT: begin
        em_data = rem_full[sddw_pkg::SYM_W-1:0];
        // last unless a minus sign still fits above this digit
        em_last = dig_final && !(neg_r && (pos_r != MAX_POS));
      end
      sddw_pkg::ACT_MINUS: begin
        em_data = sddw_pkg::SYM_MINUS;
        em_last = 1'b1;
      end
      default: begin
        em_addr = pos_r;
      end
    endcase
  end

  // Step sequencing
  always_comb begin
    step_nxt = step_r;
    if (cond_hit) begin
      step_nxt = cw.target;
    end else if (go) begin
      unique case (cw.nxt)
        sddw_pkg::NX_SEQ:  step_nxt = step_r + 1'b1;
        sddw_pkg::NX_LOOP: step_nxt = step_r;
        sddw_pkg::NX_DONE: step_nxt = sddw_pkg::STEP_LOAD;
        default:           step_nxt = sddw_pkg::STEP_LOAD;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= sddw_pkg::STEP_LOAD;
      diu_r       <= 4'd8;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (cfg_wr_en) begin
        diu_r <= cfg_wr_data;
      end
      if (go && emits) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    if (go) begin
      unique case (cw.act)
        sddw_pkg::ACT_LOAD: begin
          mag_r <= in_mag;
          neg_r <= in_value[sddw_pkg::VALUE_W-1];
          cnt_r <= blanks;
          pos_r <= sddw_pkg::FIRST_POS;
        end
        sddw_pkg::ACT_BLANK: begin
          cnt_r <= cnt_r - 1'b1;
        end
        sddw_pkg::ACT_DIGIT: begin
          mag_r <= quot;
          pos_r <= pos_r + 1'b1;
        end
        default: begin
          pos_r <= pos_r;
        end
      endcase
      if (emits) begin
        out_addr_r <= em_addr;
        out_data_r <= em_data;
        out_last_r <= em_last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r, out_addr_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/sddw_checker.sv =====
// Checker: port-level properties of the digit display writer, bound to the top level.
`timescale 1ns / 1ps

module sddw_checker #(
  parameter int MAX_DIGITS = 8
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // A stalled write stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  // An accepted value keeps the input closed the next cycle
  a_one_value: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a value is in work");

  // Written positions stay within the display
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] >= 4'd1) && (out_tdata[3:0] <= 4'(MAX_DIGITS)))
    else $error("digit position out of range");

  // Only digits, minus and blank are written; the final write is never a blank
  a_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:4] <= 4'd10) || (out_tdata[7:4] == 4'd15 && !out_tlast))
    else $error("bad symbol or last flag");

endmodule

bind signed_decimal_digit_display_writer_core sddw_checker #(
  .MAX_DIGITS(MAX_DIGITS)
) u_sddw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
